>>> hdl/xtea_pkg.sv
// ----------------------------------------------------------------------------
// xtea_pkg
// constants, types and helper functions for the address-keyed xtea encryptor
// ----------------------------------------------------------------------------
`default_nettype none

package xtea_pkg;

   typedef logic [31:0] word_type;
   typedef word_type [3:0] key_type;

   // xtea
   localparam word_type DELTA       = 32'h9E37_79B9;
   localparam int       ROUNDS      = 32;
   localparam int       HALF_STAGES = 2 * ROUNDS;

   // buffer geometry
   localparam int       INDEX_W     = 13;
   localparam int       MAX_BLOCKS  = 8192;
   localparam int       SKIP_BLOCKS = 32'h28 / 8;

   // register reset values and whitening words
   localparam word_type DEFAULT_PID = 32'h0000_1337;
   localparam word_type WHITEN_K0   = 32'h38C4_71AC;
   localparam word_type WHITEN_K1   = 32'h08D2_5804;
   localparam word_type WHITEN_K2   = 32'h3816_C16C;
   localparam word_type WHITEN_K3   = 32'h0443_D38C;

   // cipher modes
   localparam int          MODE_W         = 3;
   localparam logic [2:0]  MODE_OFF       = 3'd0;
   localparam logic [2:0]  MODE_ADDR_LO   = 3'd1;
   localparam logic [2:0]  MODE_ADDR_FULL = 3'd2;
   localparam logic [2:0]  MODE_LO_SKIP   = 3'd3;
   localparam logic [2:0]  MODE_FULL_SKIP = 3'd4;
   localparam logic [2:0]  MODE_WHITEN    = 3'd5;

   // register indexes
   localparam int         CSR_IDX_W = 2;
   localparam int         CSR_DATA_W = 64;
   localparam logic [1:0] CSR_MODE  = 2'd0;
   localparam logic [1:0] CSR_ADDR  = 2'd1;
   localparam logic [1:0] CSR_PID   = 2'd2;

   // running sum after n additions of delta, modulo 2^32
   function automatic word_type round_sum(input int unsigned n);
      word_type cnt;
      cnt = word_type'(n);
      return cnt * DELTA;
   endfunction

   // xtea feistel mixing term
   function automatic word_type mix(input word_type v);
      return ((v << 4) ^ (v >> 5)) + v;
   endfunction

endpackage

`default_nettype wire

>>> hdl/xtea_block_encrypt_keyed_by_address_core.sv
// ----------------------------------------------------------------------------
// xtea_block_encrypt_keyed_by_address_core
// 32-round xtea encryptor for 8-byte buffer blocks, keyed by address and pid
// ----------------------------------------------------------------------------
// usage:
//  - req channel: one 8-byte block per transaction, tdata carries the two
//    little-endian words and the block index, tuser the full-block flag
//  - rsp channel: one transaction per request, in order; tdata carries the
//    result words, tuser is high when the block was encrypted
//  - csr port: write-only; 0 cipher mode, 1 buffer address, 2 process id;
//    write only while no request is in flight
//  - the cipher is unrolled into 64 half-round register stages, one feistel
//    half-round per stage, plus an input stage and the output register;
//    one transaction per cycle while the pipeline is not held
//  - pass-through blocks ride the same stages with their update disabled,
//    so ordering and latency are the same for every block
//  - a two-entry output buffer (output register plus skid) sits behind the
//    last stage; when rsp_tready is low the pipeline still moves until the
//    skid entry fills, then the whole pipeline holds and req_tready drops
//  - reset (synchronous) empties the pipeline and output buffer and loads
//    mode 0, address 0 and pid 0x1337
// ----------------------------------------------------------------------------
`default_nettype none

module xtea_block_encrypt_keyed_by_address_core #(
   parameter int MAX_BLOCKS = xtea_pkg::MAX_BLOCKS
) (
   input  wire logic         clock,
   input  wire logic         reset,
   // request: [31:0] word_low, [63:32] word_high, [76:64] block_index, zero pad
   input  wire logic         req_tvalid,
   output logic              req_tready,
   input  wire logic [79:0]  req_tdata,
   // request: [0] full_block
   input  wire logic         req_tuser,
   // response: [31:0] out_low, [63:32] out_high
   output logic              rsp_tvalid,
   input  wire logic         rsp_tready,
   output logic [63:0]       rsp_tdata,
   // response: [0] was_encrypted
   output logic              rsp_tuser,
   // configuration
   input  wire logic                            csr_we,
   input  wire logic [xtea_pkg::CSR_IDX_W-1:0]  csr_index,
   input  wire logic [xtea_pkg::CSR_DATA_W-1:0] csr_wdata
);

   localparam int N = xtea_pkg::HALF_STAGES;

   // configuration registers
   logic [xtea_pkg::MODE_W-1:0] mode_ff;
   logic [63:0]                 addr_ff;
   xtea_pkg::word_type          pid_ff;
   xtea_pkg::key_type           key_in, key_ff;

   // pipeline stages: index 0 is the input stage, index k+1 follows half-round k
   logic               valid_ff [0:N];
   logic               enc_ff   [0:N];
   xtea_pkg::word_type v0_ff    [0:N];
   xtea_pkg::word_type v1_ff    [0:N];
   xtea_pkg::word_type v0_in    [1:N];
   xtea_pkg::word_type v1_in    [1:N];

   // output buffer
   logic        out_valid_ff, skid_valid_ff;
   logic [63:0] out_data_ff, skid_data_ff;
   logic        out_enc_ff, skid_enc_ff;

   logic advance;
   logic push, pop;
   logic enc_in;
   logic [xtea_pkg::INDEX_W-1:0] req_index;
   logic [16:0] index_ext;

   // ---------------------------------------------------------------------
   // configuration writes, unknown index is ignored
   // ---------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= xtea_pkg::MODE_OFF;
         addr_ff <= '0;
         pid_ff  <= xtea_pkg::DEFAULT_PID;
      end else if (csr_we) begin
         case (csr_index)
            xtea_pkg::CSR_MODE: mode_ff <= csr_wdata[xtea_pkg::MODE_W-1:0];
            xtea_pkg::CSR_ADDR: addr_ff <= csr_wdata;
            xtea_pkg::CSR_PID:  pid_ff  <= csr_wdata[31:0];
            default: ;
         endcase
      end
   end

   // key schedule words from mode, address halves and pid
   always_comb begin
      if (mode_ff == xtea_pkg::MODE_WHITEN) begin
         key_in[0] = addr_ff[31:0]  ^ xtea_pkg::WHITEN_K0;
         key_in[1] = addr_ff[63:32] ^ xtea_pkg::WHITEN_K1;
         key_in[2] = pid_ff         ^ xtea_pkg::WHITEN_K2;
         key_in[3] = xtea_pkg::WHITEN_K3;
      end else begin
         key_in[0] = addr_ff[31:0];
         key_in[1] = (mode_ff == xtea_pkg::MODE_ADDR_FULL ||
                      mode_ff == xtea_pkg::MODE_FULL_SKIP) ? addr_ff[63:32] : '0;
         key_in[2] = pid_ff;
         key_in[3] = '0;
      end
   end

   // key is first used by the half-round behind the input stage, so one register fits
   always_ff @(posedge clock) begin
      key_ff <= key_in;
   end

   // ---------------------------------------------------------------------
   // encrypt decision at the input stage
   // ---------------------------------------------------------------------
   assign req_index = req_tdata[76:64];
   assign index_ext = {4'b0, req_index};

   always_comb begin
      enc_in = (mode_ff != xtea_pkg::MODE_OFF) && req_tuser &&
               (index_ext < 17'(MAX_BLOCKS));
      // header skip for modes 3 and up
      if (mode_ff >= xtea_pkg::MODE_LO_SKIP &&
          index_ext < 17'(xtea_pkg::SKIP_BLOCKS)) begin
         enc_in = 1'b0;
      end
   end

   // the whole pipeline moves unless the output buffer is full
   assign advance    = !skid_valid_ff;
   assign req_tready = advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff[0] <= 1'b0;
      end else if (advance) begin
         valid_ff[0] <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         enc_ff[0] <= enc_in;
         v0_ff[0]  <= req_tdata[31:0];
         v1_ff[0]  <= req_tdata[63:32];
      end
   end

   // ---------------------------------------------------------------------
   // half-round stages: even stages update v0, odd stages update v1
   // ---------------------------------------------------------------------
   for (genvar h = 0; h < N; h++) begin : g_half
      localparam int unsigned    RND = h / 2;
      localparam xtea_pkg::word_type SUM = (h % 2 == 0) ?
                 xtea_pkg::round_sum(RND) : xtea_pkg::round_sum(RND + 1);
      localparam logic [1:0]     KSEL = (h % 2 == 0) ? SUM[1:0] : SUM[12:11];

      if (h % 2 == 0) begin : g_even
         always_comb begin
            v1_in[h+1] = v1_ff[h];
            v0_in[h+1] = enc_ff[h] ?
               v0_ff[h] + (xtea_pkg::mix(v1_ff[h]) ^ (SUM + key_ff[KSEL])) :
               v0_ff[h];
         end
      end else begin : g_odd
         always_comb begin
            v0_in[h+1] = v0_ff[h];
            v1_in[h+1] = enc_ff[h] ?
               v1_ff[h] + (xtea_pkg::mix(v0_ff[h]) ^ (SUM + key_ff[KSEL])) :
               v1_ff[h];
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[h+1] <= 1'b0;
         end else if (advance) begin
            valid_ff[h+1] <= valid_ff[h];
         end
      end

      always_ff @(posedge clock) begin
         if (advance) begin
            enc_ff[h+1] <= enc_ff[h];
            v0_ff[h+1]  <= v0_in[h+1];
            v1_ff[h+1]  <= v1_in[h+1];
         end
      end
   end

   // ---------------------------------------------------------------------
   // output register plus skid entry
   // ---------------------------------------------------------------------
   assign push = advance && valid_ff[N];
   assign pop  = out_valid_ff && rsp_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         if (!out_valid_ff || pop) begin
            if (skid_valid_ff) begin
               out_valid_ff  <= 1'b1;
               skid_valid_ff <= 1'b0;
            end else begin
               out_valid_ff  <= push;
            end
         end else if (push) begin
            skid_valid_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (!out_valid_ff || pop) begin
         if (skid_valid_ff) begin
            out_data_ff <= skid_data_ff;
            out_enc_ff  <= skid_enc_ff;
         end else if (push) begin
            out_data_ff <= {v1_ff[N], v0_ff[N]};
            out_enc_ff  <= enc_ff[N];
         end
      end else if (push) begin
         skid_data_ff <= {v1_ff[N], v0_ff[N]};
         skid_enc_ff  <= enc_ff[N];
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;
   assign rsp_tuser  = out_enc_ff;

   // ---------------------------------------------------------------------
   // assertions
   // ---------------------------------------------------------------------
   // skid entry is only used behind a held output register
   a_skid_behind_out: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("skid entry valid while output register empty");

   // a result arriving at a stalled full output register lands in the skid entry
   a_push_to_skid: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && !rsp_tready && push) |=> skid_valid_ff)
      else $error("result lost at stalled output");

   // a pop with the skid entry full drains it and keeps the output valid
   a_skid_drain: assert property (@(posedge clock) disable iff (reset)
      (pop && skid_valid_ff) |=> (out_valid_ff && !skid_valid_ff))
      else $error("skid entry not drained on pop");

   // after reset the output side is empty
   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> (!out_valid_ff && !skid_valid_ff && !valid_ff[0]))
      else $error("output side not empty after reset");

endmodule

`default_nettype wire
